// ===== src/zoned_stroke_nearest_centroid_assert.svh =====
// assertion macros for the stroke classifier
`ifndef ZONED_STROKE_NEAREST_CENTROID_ASSERT_SVH
`define ZONED_STROKE_NEAREST_CENTROID_ASSERT_SVH

// same-cycle implication
`define ZSNC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ZSNC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/zsnc_pkg.sv =====
package zsnc_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int NUM_CLASSES = 10;
	localparam int COORD_BITS = 12;
	localparam int COUNT_BITS = 16;

	localparam int ZONES = 9;
	localparam int PERCENT = 100;
	localparam int PT_AW = $clog2(MAX_POINTS);
	localparam int NPW = PT_AW + 1;
	localparam int FEAT_W = 7;
	localparam int CLS_W = 4;
	localparam int ZIDX_W = 4;
	localparam int CENT_DEPTH = NUM_CLASSES * ZONES;
	localparam int CA_W = $clog2(CENT_DEPTH);
	localparam int DIST_W = 17;
	localparam int ACC_W = 18;
	localparam int DIV_DW = COUNT_BITS + 1;
	localparam int DIV_NW = FEAT_W + COUNT_BITS + 1;
	localparam int DIV_CW = $clog2(DIV_NW);
	localparam int CUT_W = COORD_BITS + 2;
	localparam int DIV3_MUL = 43691;
	localparam int DIV3_SH = 17;

	typedef struct packed {
		logic [COORD_BITS-1:0] point_x;
		logic [COORD_BITS-1:0] point_y;
		logic                  last_point;
		logic                  func;
		logic [3:0]            label;
	} item_t;

	typedef struct packed {
		logic [3:0]        class_out;
		logic              was_training;
		logic [DIST_W-1:0] best_distance_sq;
	} res_t;

	typedef struct packed {
		logic accept;
		logic loop_clr;
		logic box_step;
		logic cell_calc;
		logic zone_step;
		logic sel_clr;
		logic div_pct_go;
		logic div_trn_go;
		logic feat_wr;
		logic mul_go;
		logic cent_wr;
		logic cls_sq;
		logic cls_acc;
	} cmd_t;

	typedef struct packed {
		logic loop_end;
		logic z_last;
		logic k_last;
		logic div_done;
		logic func;
		logic label_ok;
	} st_t;

endpackage

// ===== src/zsnc_div.sv =====
module zsnc_div import zsnc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [DIV_NW-1:0] quo
);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DIV_DW:0]   shifted;
	logic              fits;

	assign shifted = {rem_q, quo_q[DIV_NW-1]};
	assign fits = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? DIV_DW'(shifted - {1'b0, den_q}) : shifted[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

// ===== src/zsnc_dp.sv =====
module zsnc_dp import zsnc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	input  item_t item,
	output st_t   st,
	output res_t  result
);

	logic [COORD_BITS-1:0] mem_x [MAX_POINTS];
	logic [COORD_BITS-1:0] mem_y [MAX_POINTS];
	logic [COORD_BITS-1:0] px_rd, py_rd;
	logic [NPW-1:0]        held_q, n_q, idx_q;
	logic                  room;
	logic                  func_q;
	logic [3:0]            label_q;
	logic [COORD_BITS-1:0] minx_q, maxx_q, miny_q, maxy_q, cx_q, cy_q;
	logic [NPW-1:0]        zcnt_q [ZONES];
	logic [FEAT_W-1:0]     feat_q [ZONES];
	logic [ZIDX_W-1:0]     z_q;
	logic [CLS_W-1:0]      k_q;
	logic [FEAT_W-1:0]     cmem [CENT_DEPTH];
	logic [FEAT_W-1:0]     c_rd_q;
	logic                  c_ok_q;
	logic [NUM_CLASSES-1:0] row_ok_q;
	logic [COUNT_BITS-1:0] scnt_q [NUM_CLASSES];
	logic [DIV_NW-1:0]     prod_q;
	logic [2*FEAT_W-1:0]   sq_q;
	logic [ACC_W-1:0]      acc_q, best_q, dsum;
	logic [CLS_W-1:0]      bestk_q;
	logic [CLS_W-1:0]      row;
	logic [CA_W-1:0]       caddr;
	logic [FEAT_W-1:0]     cval, fcur, diff;
	logic [CUT_W-1:0]      lim1x, lim2x, lim1y, lim2y;
	logic [1:0]            colx, rowy;
	logic [ZIDX_W-1:0]     zi;
	logic                  div_go, div_done;
	logic [DIV_NW-1:0]     div_num, div_q;
	logic [DIV_DW-1:0]     div_den;
	logic [COORD_BITS-1:0] ext_x, ext_y;

	assign room = held_q < NPW'(MAX_POINTS);

	always_ff @(posedge clk) begin
		if (cmd.accept && room) begin
			mem_x[held_q[PT_AW-1:0]] <= item.point_x;
			mem_y[held_q[PT_AW-1:0]] <= item.point_y;
		end
		px_rd <= mem_x[idx_q[PT_AW-1:0]];
		py_rd <= mem_y[idx_q[PT_AW-1:0]];
	end

	assign ext_x = maxx_q - minx_q;
	assign ext_y = maxy_q - miny_q;
	assign lim1x = CUT_W'(minx_q) + CUT_W'(cx_q);
	assign lim2x = lim1x + CUT_W'(cx_q);
	assign lim1y = CUT_W'(miny_q) + CUT_W'(cy_q);
	assign lim2y = lim1y + CUT_W'(cy_q);
	assign colx = (CUT_W'(px_rd) < lim1x) ? 2'd0 : (CUT_W'(px_rd) < lim2x) ? 2'd1 : 2'd2;
	assign rowy = (CUT_W'(py_rd) < lim1y) ? 2'd0 : (CUT_W'(py_rd) < lim2y) ? 2'd1 : 2'd2;
	assign zi = ZIDX_W'(rowy) * ZIDX_W'(3) + ZIDX_W'(colx);

	assign row = func_q ? label_q : k_q;
	assign caddr = CA_W'(int'(row) * ZONES + int'(z_q));
	assign cval = c_ok_q ? c_rd_q : '0;
	assign fcur = feat_q[z_q];
	assign diff = (fcur > cval) ? fcur - cval : cval - fcur;
	assign dsum = acc_q + ACC_W'(sq_q);

	assign div_go = cmd.div_pct_go || cmd.div_trn_go;
	assign div_num = cmd.div_pct_go ? DIV_NW'(zcnt_q[z_q]) * DIV_NW'(PERCENT)
		: prod_q + DIV_NW'(fcur);
	assign div_den = cmd.div_pct_go ? DIV_DW'(n_q) : DIV_DW'(scnt_q[label_q]) + 1'b1;

	zsnc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_go),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			n_q <= '0;
			idx_q <= '0;
			func_q <= 1'b0;
			label_q <= '0;
			z_q <= '0;
			k_q <= '0;
			row_ok_q <= '0;
			for (int i = 0; i < ZONES; i++) zcnt_q[i] <= '0;
			for (int i = 0; i < NUM_CLASSES; i++) scnt_q[i] <= '0;
		end else begin
			if (cmd.accept) begin
				if (item.last_point) begin
					held_q <= '0;
					n_q <= held_q + NPW'(room);
					func_q <= item.func;
					label_q <= item.label;
				end else if (room) begin
					held_q <= held_q + 1'b1;
				end
			end
			if (cmd.loop_clr) begin
				idx_q <= '0;
			end else if ((cmd.box_step || cmd.zone_step) && idx_q != n_q) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.cell_calc) begin
				for (int i = 0; i < ZONES; i++) zcnt_q[i] <= '0;
			end else if (cmd.zone_step && idx_q != '0) begin
				zcnt_q[zi] <= zcnt_q[zi] + 1'b1;
			end
			if (cmd.sel_clr) begin
				z_q <= '0;
				k_q <= '0;
			end else if (cmd.feat_wr || cmd.cent_wr) begin
				z_q <= z_q + 1'b1;
			end else if (cmd.cls_acc) begin
				if (st.z_last) begin
					z_q <= '0;
					k_q <= k_q + 1'b1;
				end else begin
					z_q <= z_q + 1'b1;
				end
			end
			if (cmd.cent_wr && st.z_last) begin
				row_ok_q[row] <= 1'b1;
				if (scnt_q[label_q] != '1) scnt_q[label_q] <= scnt_q[label_q] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.box_step && idx_q != '0) begin
			if (idx_q == NPW'(1)) begin
				minx_q <= px_rd;
				maxx_q <= px_rd;
				miny_q <= py_rd;
				maxy_q <= py_rd;
			end else begin
				if (px_rd < minx_q) minx_q <= px_rd;
				if (px_rd > maxx_q) maxx_q <= px_rd;
				if (py_rd < miny_q) miny_q <= py_rd;
				if (py_rd > maxy_q) maxy_q <= py_rd;
			end
		end
		if (cmd.cell_calc) begin
			cx_q <= COORD_BITS'((32'(ext_x) * 32'(DIV3_MUL)) >> DIV3_SH);
			cy_q <= COORD_BITS'((32'(ext_y) * 32'(DIV3_MUL)) >> DIV3_SH);
		end
		if (cmd.feat_wr) feat_q[z_q] <= div_q[FEAT_W-1:0];
		if (cmd.cent_wr) cmem[caddr] <= div_q[FEAT_W-1:0];
		c_rd_q <= cmem[caddr];
		c_ok_q <= row_ok_q[row];
		if (cmd.mul_go) prod_q <= DIV_NW'(cval) * DIV_NW'(scnt_q[label_q]);
		if (cmd.cls_sq) sq_q <= (2*FEAT_W)'(diff) * (2*FEAT_W)'(diff);
		if (cmd.sel_clr) begin
			acc_q <= '0;
		end else if (cmd.cls_acc) begin
			acc_q <= st.z_last ? '0 : dsum;
			if (st.z_last && (k_q == '0 || dsum < best_q)) begin
				best_q <= dsum;
				bestk_q <= k_q;
			end
		end
	end

	assign st.loop_end = idx_q == n_q;
	assign st.z_last = z_q == ZIDX_W'(ZONES - 1);
	assign st.k_last = k_q == CLS_W'(NUM_CLASSES - 1);
	assign st.div_done = div_done;
	assign st.func = func_q;
	assign st.label_ok = label_q < CLS_W'(NUM_CLASSES);

	assign result.class_out = func_q ? label_q : bestk_q;
	assign result.was_training = func_q;
	assign result.best_distance_sq = func_q ? '0 : best_q[DIST_W-1:0];

endmodule

// ===== src/zsnc_ctrl.sv =====
module zsnc_ctrl import zsnc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic last_point,
	input  st_t  st,
	output cmd_t cmd,
	output logic busy,
	output logic done
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_BOX   = 4'd1;
	localparam logic [3:0] S_CELL  = 4'd2;
	localparam logic [3:0] S_ZONE  = 4'd3;
	localparam logic [3:0] S_PGO   = 4'd4;
	localparam logic [3:0] S_PWAIT = 4'd5;
	localparam logic [3:0] S_TRD   = 4'd6;
	localparam logic [3:0] S_TMUL  = 4'd7;
	localparam logic [3:0] S_TGO   = 4'd8;
	localparam logic [3:0] S_TWAIT = 4'd9;
	localparam logic [3:0] S_CRD   = 4'd10;
	localparam logic [3:0] S_CSQ   = 4'd11;
	localparam logic [3:0] S_CACC  = 4'd12;
	localparam logic [3:0] S_RES   = 4'd13;

	logic [3:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.loop_clr = 1'b1;
				if (start) begin
					cmd.accept = 1'b1;
					if (last_point) state_d = S_BOX;
				end
			end
			S_BOX: begin
				cmd.box_step = 1'b1;
				if (st.loop_end) state_d = S_CELL;
			end
			S_CELL: begin
				cmd.cell_calc = 1'b1;
				cmd.loop_clr = 1'b1;
				cmd.sel_clr = 1'b1;
				state_d = S_ZONE;
			end
			S_ZONE: begin
				cmd.zone_step = 1'b1;
				if (st.loop_end) state_d = S_PGO;
			end
			S_PGO: begin
				cmd.div_pct_go = 1'b1;
				state_d = S_PWAIT;
			end
			S_PWAIT: begin
				if (st.div_done) begin
					cmd.feat_wr = 1'b1;
					if (st.z_last) begin
						cmd.sel_clr = 1'b1;
						if (!st.func) state_d = S_CRD;
						else if (st.label_ok) state_d = S_TRD;
						else state_d = S_IDLE;
					end else begin
						state_d = S_PGO;
					end
				end
			end
			S_TRD: state_d = S_TMUL;
			S_TMUL: begin
				cmd.mul_go = 1'b1;
				state_d = S_TGO;
			end
			S_TGO: begin
				cmd.div_trn_go = 1'b1;
				state_d = S_TWAIT;
			end
			S_TWAIT: begin
				if (st.div_done) begin
					cmd.cent_wr = 1'b1;
					state_d = st.z_last ? S_RES : S_TRD;
				end
			end
			S_CRD: state_d = S_CSQ;
			S_CSQ: begin
				cmd.cls_sq = 1'b1;
				state_d = S_CACC;
			end
			S_CACC: begin
				cmd.cls_acc = 1'b1;
				state_d = (st.z_last && st.k_last) ? S_RES : S_CRD;
			end
			S_RES: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_RES;

endmodule

// ===== src/zoned_stroke_nearest_centroid.sv =====
// Stroke classifier: a point is transferred when start is high and busy is low. A point
// without last_point leaves busy low, and the block is ready again the next cycle. A
// point with last_point starts the end-of-stroke pass: two walks over the point store
// (one point store read per cycle), nine percent divisions in a shared bit-serial
// divider, then either 9 centroid updates (same divider) or 90 distance terms on one
// squarer. Busy is high for the whole pass. The result appears on result for exactly
// one cycle with done high and must be taken then; the receiver cannot stall it. A
// training label of 10 or more updates nothing and gives no result.
module zoned_stroke_nearest_centroid import zsnc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  item_t item,
	output logic  done,
	output res_t  result
);

`include "zoned_stroke_nearest_centroid_assert.svh"

	cmd_t cmd;
	st_t  st;

	zsnc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_point(item.last_point),
		.st        (st),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	zsnc_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.item  (item),
		.st    (st),
		.result(result)
	);

	`ZSNC_ASSERT_NOW(a_done_busy, done, busy, "result strobe outside a busy pass")
	`ZSNC_ASSERT_NEXT(a_done_once, done, !done, "more than one result for a stroke")
	`ZSNC_ASSERT_NEXT(a_plain_point, start && !busy && !item.last_point, !busy,
		"plain point held the block busy")
	`ZSNC_ASSERT_NOW(a_train_zero, done && result.was_training,
		result.best_distance_sq == '0, "training result carries a distance")

endmodule

// ===== sim/zoned_stroke_nearest_centroid_tb.sv =====
module zoned_stroke_nearest_centroid_tb;
	import zsnc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam logic FUNC_CLASSIFY = 1'b0;
	localparam logic FUNC_TRAIN = 1'b1;
	localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic done;
	res_t result;

	zoned_stroke_nearest_centroid dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	item_t point_queue[$];
	res_t expected_results[$];

	logic [COORD_BITS-1:0] held_x[MAX_POINTS];
	logic [COORD_BITS-1:0] held_y[MAX_POINTS];
	int held_count;
	int centroid[NUM_CLASSES][ZONES];
	int sample_count[NUM_CLASSES];

	int error_count;
	int idle_cycles;
	int gap_left;
	logic stimulus_done;
	logic busy_at_edge;
	logic accepted_at_edge;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	function automatic int band_of(input int v, input int lo, input int cell_w);
		if (v < lo + cell_w)
			return 0;
		if (v < lo + 2 * cell_w)
			return 1;
		return 2;
	endfunction

	// stroke accumulation, feature extraction, centroid update and classification
	task automatic predict_point(input item_t it);
		int minx, maxx, miny, maxy, cx, cy, zi, d, diff, best, bestd, n;
		int zc[ZONES];
		int feat[ZONES];
		longint acc;
		res_t r;
		if (held_count < MAX_POINTS) begin
			held_x[held_count] = it.point_x;
			held_y[held_count] = it.point_y;
			held_count++;
		end
		if (!it.last_point)
			return;
		n = held_count;
		minx = held_x[0];
		maxx = minx;
		miny = held_y[0];
		maxy = miny;
		for (int i = 1; i < n; i++) begin
			if (held_x[i] < minx) minx = held_x[i];
			if (held_x[i] > maxx) maxx = held_x[i];
			if (held_y[i] < miny) miny = held_y[i];
			if (held_y[i] > maxy) maxy = held_y[i];
		end
		cx = (maxx - minx) / 3;
		cy = (maxy - miny) / 3;
		foreach (zc[i]) zc[i] = 0;
		for (int i = 0; i < n; i++) begin
			zi = band_of(held_y[i], miny, cy) * 3 + band_of(held_x[i], minx, cx);
			zc[zi]++;
		end
		foreach (feat[i]) feat[i] = (zc[i] * PERCENT) / n;
		held_count = 0;
		if (it.func == FUNC_TRAIN) begin
			if (it.label >= NUM_CLASSES)
				return;
			for (int i = 0; i < ZONES; i++) begin
				acc = longint'(centroid[it.label][i]) * sample_count[it.label] + feat[i];
				centroid[it.label][i] = int'(acc / (sample_count[it.label] + 1)) & 8'h7f;
			end
			if (sample_count[it.label] < COUNT_MAX)
				sample_count[it.label]++;
			r.class_out = it.label;
			r.was_training = 1'b1;
			r.best_distance_sq = '0;
		end else begin
			best = 0;
			bestd = 0;
			for (int k = 0; k < NUM_CLASSES; k++) begin
				d = 0;
				for (int i = 0; i < ZONES; i++) begin
					diff = feat[i] - centroid[k][i];
					d += diff * diff;
				end
				if (k == 0 || d < bestd) begin
					bestd = d;
					best = k;
				end
			end
			r.class_out = best[3:0];
			r.was_training = 1'b0;
			r.best_distance_sq = bestd[DIST_W-1:0];
		end
		expected_results.push_back(r);
	endtask

	function automatic item_t make_point(input int x, input int y, input logic last,
			input logic fn, input int lbl);
		item_t it;
		it.point_x = x[COORD_BITS-1:0];
		it.point_y = y[COORD_BITS-1:0];
		it.last_point = last;
		it.func = fn;
		it.label = lbl[3:0];
		return it;
	endfunction

	// a stroke of n points in a random box; noise fields on the inner points
	task automatic queue_stroke(input int n, input logic fn, input int lbl, input int span);
		int x0, y0;
		x0 = $urandom_range(0, 4095 - span);
		y0 = $urandom_range(0, 4095 - span);
		for (int i = 0; i < n; i++)
			point_queue.push_back(make_point(x0 + $urandom_range(0, span),
				y0 + $urandom_range(0, span), i == n - 1,
				(i == n - 1) ? fn : logic'($urandom_range(0, 1)),
				(i == n - 1) ? lbl : $urandom_range(0, 15)));
	endtask

	initial begin
		int lbl;
		int span;
		logic fn;
		error_count = 0;
		stimulus_done = 1'b0;
		held_count = 0;
		foreach (sample_count[k]) begin
			sample_count[k] = 0;
			foreach (centroid[k][i]) centroid[k][i] = 0;
		end
		// directed: extremes, single point, narrow box, out-of-range labels, tie on empty centroids
		point_queue.push_back(make_point(0, 0, 1, FUNC_CLASSIFY, 0));
		point_queue.push_back(make_point(4095, 4095, 1, FUNC_TRAIN, 9));
		point_queue.push_back(make_point(0, 4095, 0, FUNC_TRAIN, 15));
		point_queue.push_back(make_point(4095, 0, 0, FUNC_CLASSIFY, 5));
		point_queue.push_back(make_point(2730, 1365, 1, FUNC_TRAIN, 3));
		point_queue.push_back(make_point(100, 100, 0, FUNC_CLASSIFY, 0));
		point_queue.push_back(make_point(102, 101, 1, FUNC_CLASSIFY, 0));
		point_queue.push_back(make_point(5, 5, 1, FUNC_TRAIN, 10));
		point_queue.push_back(make_point(5, 6, 1, FUNC_TRAIN, 15));
		queue_stroke(6, FUNC_TRAIN, 0, 4095);
		queue_stroke(6, FUNC_CLASSIFY, 0, 2);
		// random strokes of 1 to 12 points, then one filling the store past capacity
		while (point_queue.size() < 1350 - (MAX_POINTS + 5)) begin
			lbl = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
			fn = logic'($urandom_range(0, 2) != 0);
			span = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : $urandom_range(3, 4095);
			queue_stroke($urandom_range(1, 12), fn, lbl, span);
		end
		queue_stroke(MAX_POINTS + 5, FUNC_TRAIN, 4, 4095);
		stimulus_done = 1'b1;
	end

	initial begin
		start = 1'b0;
		item = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (accepted_at_edge) begin
				predict_point(item);
				void'(point_queue.pop_front());
			end
			if (start && busy_at_edge) begin
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (point_queue.size() != 0) begin
				start <= 1'b1;
				item <= point_queue[0];
				gap_left <= ($urandom_range(0, 9) < 6) ? 0 :
					(($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) :
					$urandom_range(1, 3));
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			busy_at_edge <= 1'b1;
			accepted_at_edge <= 1'b0;
			idle_cycles <= 0;
		end else begin
			busy_at_edge <= busy;
			accepted_at_edge <= start && !busy;
			if (start && !busy)
				idle_cycles <= 0;
			else if (done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result transfer", 1, 0);
				end else begin
					want = expected_results.pop_front();
					if (result.class_out !== want.class_out)
						report_mismatch("class_out", result.class_out, want.class_out);
					if (result.was_training !== want.was_training)
						report_mismatch("was_training", result.was_training,
							want.was_training);
					if (result.best_distance_sq !== want.best_distance_sq)
						report_mismatch("best_distance_sq", result.best_distance_sq,
							want.best_distance_sq);
				end
			end
		end
	end

	initial begin
		gap_left = 0;
		wait (arst_n);
		while (!(stimulus_done && point_queue.size() == 0 && !start &&
				expected_results.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("zoned_stroke_nearest_centroid_tb: FAIL");
			$finish;
		end else begin
			repeat (3000) @(posedge clk);
			if (error_count == 0 && expected_results.size() == 0)
				$display("zoned_stroke_nearest_centroid_tb: PASS");
			else
				$display("zoned_stroke_nearest_centroid_tb: FAIL");
			$finish;
		end
	end

endmodule

// ===== files.f =====
+incdir+src
src/zsnc_pkg.sv
src/zsnc_div.sv
src/zsnc_dp.sv
src/zsnc_ctrl.sv
src/zoned_stroke_nearest_centroid.sv
sim/zoned_stroke_nearest_centroid_tb.sv
